// ===== src/ipv4fhb_pkg.sv =====
package ipv4fhb_pkg;

  // header constants
  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [7:0]  TTL_VALUE    = 8'd64;
  localparam logic [10:0] HDR_LEN      = 11'd20;
  localparam logic [10:0] ETH_HDR_LEN  = 11'd14;
  localparam logic [10:0] MTU_LOW      = 11'd1044;
  localparam logic [10:0] MTU_HIGH     = 11'd1500;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MTU       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SETUP,
    ST_SUM,
    ST_OUT
  } state_t;

  // control of the shared checksum accumulator
  typedef struct packed {
    logic clear;    // acc <= 0
    logic restore;  // acc <= saved packet base sum
    logic add;      // acc <= acc +' word
    logic keep;     // also save the add result as packet base sum
  } csum_ctl_t;

endpackage

// ===== src/ipv4fhb_if.sv =====
interface ipv4fhb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_addr;
  logic [7:0]  protocol;
  logic [15:0] segment_length;

  modport source (output valid, dest_addr, protocol, segment_length, input ready);
  modport sink   (input valid, dest_addr, protocol, segment_length, output ready);
endinterface

interface ipv4fhb_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] total_length;
  logic [15:0] ident;
  logic [13:0] frag_word;
  logic [15:0] header_sum;
  logic [15:0] payload_offset;
  logic [10:0] payload_length;
  logic [10:0] frame_length;
  logic        last;

  modport source (output valid, total_length, ident, frag_word, header_sum,
                  payload_offset, payload_length, frame_length, last, input ready);
  modport sink   (input valid, total_length, ident, frag_word, header_sum,
                  payload_offset, payload_length, frame_length, last, output ready);
endinterface

// ===== src/ipv4fhb_csum.sv =====
module ipv4fhb_csum
  import ipv4fhb_pkg::*;
(
  input  logic        clk,
  input  csum_ctl_t   ctl,
  input  logic [15:0] word,
  output logic [15:0] sum
);

  logic [15:0] acc_r;
  logic [15:0] base_r;
  logic [16:0] raw;
  logic [15:0] folded;

  // ones' complement add with end-around carry
  assign raw    = {1'b0, acc_r} + {1'b0, word};
  assign folded = raw[15:0] + {15'd0, raw[16]};
  assign sum    = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= 16'd0;
    end else if (ctl.restore) begin
      acc_r <= base_r;
    end else if (ctl.add) begin
      acc_r <= folded;
    end
    if (ctl.keep) begin
      base_r <= folded;
    end
  end

endmodule

// ===== src/ipv4_fragment_header_builder_unit.sv =====
// IPv4 header builder with fragmentation. Each input beat describes one
// outgoing transport segment (destination, protocol, length) and yields one
// or more header beats, the final one flagged with last. The packet
// identifier starts at 1 after reset, advances once per input and wraps at
// 16 bits. A segment that fits in mtu - 20 bytes gives a single header;
// a longer one is cut into fragments of (mtu - 20) rounded down to a
// multiple of 8 bytes, more-fragments set on all but the last. mtu is
// clamped to 1044..1500 so a segment never needs more than 64 fragments.
// All checksum arithmetic goes through one 16-bit ones' complement adder:
// the six header words that are fixed for the packet (version/ihl,
// ttl/protocol, source and destination addresses) are summed once, one
// word per cycle, then each fragment restores that base sum and adds its
// total length, identifier and flag/offset word. An input therefore
// passes through the accept step and the six base adds, then for each
// header through setup, 3 adds and the output beat, the last of which
// back-pressure can hold until it is taken. in_ch.ready is
// high only while no packet is in progress. Configuration registers
// (index 0 src_addr, 1 mtu, 2 min_frame) are written through cfg_we and
// must only be changed while the block is idle.
module ipv4_fragment_header_builder_unit
  import ipv4fhb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ipv4fhb_in_if.sink            in_ch,
  ipv4fhb_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [31:0]           cfg_wdata
);

  localparam logic [2:0] BASE_LAST = 3'd5;  // six fixed header words
  localparam logic [2:0] SUM_LAST  = 3'd2;  // three per-fragment words

  // control state
  state_t      state_r, state_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [31:0] src_addr_r;
  logic [10:0] mtu_r;
  logic [6:0]  min_frame_r;

  // per packet
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [15:0] id_r, id_nxt;
  logic [10:0] room_r, room_nxt;
  logic [10:0] step_r, step_nxt;
  logic [2:0]  idx_r, idx_nxt;

  // per fragment
  logic [15:0] off_r, off_nxt;
  logic [10:0] len_r, len_nxt;
  logic        more_r, more_nxt;
  logic [10:0] total_r, total_nxt;
  logic [13:0] fw_r, fw_nxt;
  logic [10:0] frame_r, frame_nxt;

  // shared checksum unit
  csum_ctl_t   csum_ctl;
  logic [15:0] csum_word;
  logic [15:0] csum_sum;

  // combinational helpers
  logic [10:0] mtu_clamped;
  logic [10:0] room_calc;
  logic [15:0] rest;
  logic [10:0] eth_len;
  logic [10:0] min_frame_ext;

  ipv4fhb_csum u_csum (
    .clk  (clk),
    .ctl  (csum_ctl),
    .word (csum_word),
    .sum  (csum_sum)
  );

  // clamp mtu into the supported range
  always_comb begin
    if (mtu_r < MTU_LOW) begin
      mtu_clamped = MTU_LOW;
    end else if (mtu_r > MTU_HIGH) begin
      mtu_clamped = MTU_HIGH;
    end else begin
      mtu_clamped = mtu_r;
    end
  end

  assign room_calc     = mtu_clamped - HDR_LEN;
  assign rest          = seg_r - off_r;
  assign min_frame_ext = {4'd0, min_frame_r};

  always_comb begin
    state_nxt = state_r;
    ident_nxt = ident_r;
    dst_nxt   = dst_r;
    proto_nxt = proto_r;
    seg_nxt   = seg_r;
    id_nxt    = id_r;
    room_nxt  = room_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    more_nxt  = more_r;
    total_nxt = total_r;
    fw_nxt    = fw_r;
    frame_nxt = frame_r;
    eth_len   = 11'd0;
    csum_ctl  = '0;
    csum_word = 16'd0;
    in_ch.ready = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          dst_nxt   = in_ch.dest_addr;
          proto_nxt = in_ch.protocol;
          seg_nxt   = in_ch.segment_length;
          id_nxt    = ident_r;
          ident_nxt = ident_r + 16'd1;
          room_nxt  = room_calc;
          step_nxt  = {room_calc[10:3], 3'b000};
          off_nxt   = 16'd0;
          idx_nxt   = 3'd0;
          csum_ctl.clear = 1'b1;
          state_nxt = ST_BASE;
        end
      end

      // sum the words that are fixed for the whole packet
      ST_BASE: begin
        csum_ctl.add = 1'b1;
        case (idx_r)
          3'd0:    csum_word = VER_IHL_WORD;
          3'd1:    csum_word = {TTL_VALUE, proto_r};
          3'd2:    csum_word = src_addr_r[31:16];
          3'd3:    csum_word = src_addr_r[15:0];
          3'd4:    csum_word = dst_r[31:16];
          default: csum_word = dst_r[15:0];
        endcase
        if (idx_r == BASE_LAST) begin
          csum_ctl.keep = 1'b1;
          state_nxt     = ST_SETUP;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      // size this fragment and restart the sum from the packet base
      ST_SETUP: begin
        if (rest > {5'd0, room_r}) begin
          len_nxt  = step_r;
          more_nxt = 1'b1;
        end else begin
          len_nxt  = rest[10:0];
          more_nxt = 1'b0;
        end
        total_nxt = len_nxt + HDR_LEN;
        fw_nxt    = {more_nxt, off_r[15:3]};
        eth_len   = total_nxt + ETH_HDR_LEN;
        frame_nxt = (eth_len < min_frame_ext) ? min_frame_ext : eth_len;
        csum_ctl.restore = 1'b1;
        idx_nxt   = 3'd0;
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        csum_ctl.add = 1'b1;
        case (idx_r)
          3'd0:    csum_word = {5'd0, total_r};
          3'd1:    csum_word = id_r;
          default: csum_word = {2'd0, fw_r};
        endcase
        if (idx_r == SUM_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      // hold the header beat until it is taken
      ST_OUT: begin
        if (out_ch.ready) begin
          if (more_r) begin
            off_nxt   = off_r + {5'd0, step_r};
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ident_r     <= 16'd1;
      src_addr_r  <= 32'd0;
      mtu_r       <= 11'd1500;
      min_frame_r <= 7'd60;
    end else begin
      state_r <= state_nxt;
      ident_r <= ident_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_SRC_ADDR:  src_addr_r  <= cfg_wdata;
          REG_MTU:       mtu_r       <= cfg_wdata[10:0];
          REG_MIN_FRAME: min_frame_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dst_r   <= dst_nxt;
    proto_r <= proto_nxt;
    seg_r   <= seg_nxt;
    id_r    <= id_nxt;
    room_r  <= room_nxt;
    step_r  <= step_nxt;
    idx_r   <= idx_nxt;
    off_r   <= off_nxt;
    len_r   <= len_nxt;
    more_r  <= more_nxt;
    total_r <= total_nxt;
    fw_r    <= fw_nxt;
    frame_r <= frame_nxt;
  end

  // output beat straight from registers
  assign out_ch.valid          = (state_r == ST_OUT);
  assign out_ch.total_length   = total_r;
  assign out_ch.ident          = id_r;
  assign out_ch.frag_word      = fw_r;
  assign out_ch.header_sum     = ~csum_sum;
  assign out_ch.payload_offset = off_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.frame_length   = frame_r;
  assign out_ch.last           = ~more_r;

endmodule

// ===== verif/tb_ipv4_fragment_header_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_ipv4_fragment_header_builder_unit;
  import ipv4fhb_pkg::*;

  // index 3 is not a register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // slowest legal run is well under half of this
  localparam int CYCLE_LIMIT = 4000000;

  // one header beat as it leaves the block, field order as on the port
  typedef struct packed {
    logic [10:0] total_length;
    logic [15:0] ident;
    logic [13:0] frag_word;
    logic [15:0] header_sum;
    logic [15:0] payload_offset;
    logic [10:0] payload_length;
    logic [10:0] frame_length;
    logic        last;
  } hdr_beat_t;

  typedef enum logic {ROW_SEG, ROW_CFG} row_kind_t;

  // one line of the directed stimulus: either a segment or a register write
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           value;
    logic [31:0]           dest;
    logic [7:0]            proto;
    logic [15:0]           seg_len;
    bit                    typed;
    hdr_beat_t             beat;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0] cfg_wdata;

  ipv4fhb_in_if  in_ch ();
  ipv4fhb_out_if out_ch ();

  ipv4_fragment_header_builder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block: registers and the packet id counter
  logic [31:0] src_addr_reg  = 32'd0;
  logic [10:0] mtu_reg       = 11'd1500;
  logic [6:0]  min_frame_reg = 7'd60;
  logic [15:0] next_ident    = 16'd1;

  // header beats still owed by the block, oldest first
  hdr_beat_t pending_headers[$];
  dir_row_t  dir_rows[$];

  bit idling = 1'b1;
  int mismatches = 0;
  int segments_sent = 0;
  int beats_checked = 0;
  int fragmented_count = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ones' complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // usable payload bytes per packet, mtu clamped to its legal window
  function automatic int unsigned payload_room();
    int unsigned m;
    m = 32'(mtu_reg);
    if (m < 32'(MTU_LOW)) m = 32'(MTU_LOW);
    if (m > 32'(MTU_HIGH)) m = 32'(MTU_HIGH);
    return m - 32'(HDR_LEN);
  endfunction

  // one header: lengths, flag/offset word, padding and the header checksum
  function automatic hdr_beat_t make_header(input logic [15:0] id, input int unsigned off,
                                            input int unsigned len, input bit more,
                                            input logic [7:0] proto, input logic [31:0] dst);
    hdr_beat_t h;
    logic [15:0] acc;
    int unsigned frame;
    h.payload_length = 11'(len);
    h.total_length   = HDR_LEN + 11'(len);
    h.ident          = id;
    h.frag_word      = {more, 13'(off >> 3)};
    h.payload_offset = 16'(off);
    frame = 32'(ETH_HDR_LEN) + 32'(h.total_length);
    // short frames padded up to the minimum
    if (frame < 32'(min_frame_reg)) frame = 32'(min_frame_reg);
    h.frame_length = 11'(frame);
    h.last = !more;
    // checksum word slot itself counts as zero
    acc = oc_add(VER_IHL_WORD, {5'd0, h.total_length});
    acc = oc_add(acc, id);
    acc = oc_add(acc, {2'd0, h.frag_word});
    acc = oc_add(acc, {TTL_VALUE, proto});
    acc = oc_add(acc, src_addr_reg[31:16]);
    acc = oc_add(acc, src_addr_reg[15:0]);
    acc = oc_add(acc, dst[31:16]);
    acc = oc_add(acc, dst[15:0]);
    h.header_sum = ~acc;
    return h;
  endfunction

  // expected header beats for one accepted segment
  function automatic void predict_headers(input logic [31:0] dst, input logic [7:0] proto,
                                          input logic [15:0] len);
    int unsigned room, frag_len, off, rest, n, seg;
    logic [15:0] id;
    seg = 32'(len);
    room = payload_room();
    frag_len = room & ~32'd7;
    id = next_ident;
    next_ident = next_ident + 16'd1;
    // fits in one packet, empty segment included
    if (seg <= room) begin
      pending_headers.push_back(make_header(id, 0, seg, 1'b0, proto, dst));
      return;
    end
    fragmented_count++;
    off = 0;
    n = 0;
    // full 8-byte aligned fragments, then whatever is left once it fits
    while (off < seg && n < 64) begin
      rest = seg - off;
      if (rest > room) begin
        pending_headers.push_back(make_header(id, off, frag_len, 1'b1, proto, dst));
        off += frag_len;
      end else begin
        pending_headers.push_back(make_header(id, off, rest, 1'b0, proto, dst));
        off = seg;
      end
      n++;
    end
  endfunction

  // directed table builders
  function automatic void plan_seg(input logic [31:0] dst, input logic [7:0] proto,
                                   input logic [15:0] len);
    dir_row_t r;
    r = '{kind: ROW_SEG, reg_idx: REG_SRC_ADDR, value: 32'd0, dest: dst, proto: proto,
          seg_len: len, typed: 1'b0, beat: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void plan_typed(input logic [31:0] dst, input logic [7:0] proto,
                                     input logic [15:0] len, input hdr_beat_t beat);
    dir_row_t r;
    r = '{kind: ROW_SEG, reg_idx: REG_SRC_ADDR, value: 32'd0, dest: dst, proto: proto,
          seg_len: len, typed: 1'b1, beat: beat};
    dir_rows.push_back(r);
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    dir_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, value: value, dest: 32'd0, proto: 8'd0,
          seg_len: 16'd0, typed: 1'b0, beat: '0};
    dir_rows.push_back(r);
  endfunction

  // register write, cfg_we held low in front of it so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_ADDR:  src_addr_reg  = value;
      REG_MTU:       mtu_reg       = value[10:0];
      REG_MIN_FRAME: min_frame_reg = value[6:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // push one segment beat, random gaps in front while idling is set, valid left high on return
  task automatic send_segment(input logic [31:0] dst, input logic [7:0] proto,
                              input logic [15:0] len, input bit typed, input hdr_beat_t beat);
    while (idling && ($urandom_range(99) < 38)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.dest_addr      <= dst;
    in_ch.protocol       <= proto;
    in_ch.segment_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    predict_headers(dst, proto, len);
    // hand-computed beat takes the place of the predicted one
    if (typed) pending_headers[pending_headers.size() - 1] = beat;
    segments_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every owed beat come out before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_headers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // sink side back-pressure, random while idling is set
  always @(negedge clk) begin
    out_ch.ready <= !(idling && ($urandom_range(99) < 38));
  end

  // header beat checker
  always @(posedge clk) begin
    hdr_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_headers.size() == 0) begin
        $display("%0t: header beat with nothing expected, ident %0h offset %0d", $time,
                 out_ch.ident, out_ch.payload_offset);
        mismatches++;
      end else begin
        want = pending_headers.pop_front();
        check_field("total_length", 16'(want.total_length), 16'(out_ch.total_length));
        check_field("ident", want.ident, out_ch.ident);
        check_field("frag_word", 16'(want.frag_word), 16'(out_ch.frag_word));
        check_field("header_sum", want.header_sum, out_ch.header_sum);
        check_field("payload_offset", want.payload_offset, out_ch.payload_offset);
        check_field("payload_length", 16'(want.payload_length),
                    16'(out_ch.payload_length));
        check_field("frame_length", 16'(want.frame_length), 16'(out_ch.frame_length));
        check_field("last", 16'(want.last), 16'(out_ch.last));
        beats_checked++;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles, %0d beats still owed", $time,
             CYCLE_LIMIT, pending_headers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int pick;
    int unsigned room;
    logic [15:0] len;
    logic [31:0] cfg_word;
    logic [10:0] mtu_val;

    // everything known from time zero
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_SRC_ADDR;
    cfg_wdata            = 32'd0;
    in_ch.valid          = 1'b0;
    in_ch.dest_addr      = 32'd0;
    in_ch.protocol       = 8'd0;
    in_ch.segment_length = 16'd0;
    out_ch.ready         = 1'b0;

    // directed table, reset values of the registers apply at first
    // empty segments right after reset: ident 1 then 2, padded to 60
    plan_typed(32'h0000_0000, 8'h00, 16'd0,
               {11'd20, 16'd1, 14'd0, 16'h7aea, 16'd0, 11'd0, 11'd60, 1'b1});
    plan_typed(32'hffff_ffff, 8'hff, 16'd0,
               {11'd20, 16'd2, 14'd0, 16'h79ea, 16'd0, 11'd0, 11'd60, 1'b1});
    // largest unfragmented packet at the default mtu
    plan_typed(32'h0000_0000, 8'h00, 16'd1480,
               {11'd1500, 16'd3, 14'd0, 16'h7520, 16'd0, 11'd1480, 11'd1514, 1'b1});
    plan_seg(32'hc0a8_0001, 8'h06, 16'd1481);
    plan_seg(32'h0a00_0001, 8'h11, 16'hffff);
    plan_seg(32'h7f00_0001, 8'h01, 16'd1);
    plan_cfg(REG_SRC_ADDR, 32'hffff_ffff);
    plan_cfg(REG_MIN_FRAME, 32'd0);
    plan_seg(32'hffff_ffff, 8'h00, 16'd0);
    // smallest legal mtu: a maximal segment needs all 64 fragments
    plan_cfg(REG_MTU, 32'd1044);
    plan_seg(32'h1234_5678, 8'h11, 16'hffff);
    plan_seg(32'h8765_4321, 8'h06, 16'd1024);
    plan_seg(32'h5555_aaaa, 8'h2f, 16'd1025);
    // mtu under range is clamped up
    plan_cfg(REG_MTU, 32'd1043);
    plan_seg(32'haaaa_5555, 8'h32, 16'd2049);
    plan_cfg(REG_MTU, 32'd0);
    plan_seg(32'h0102_0304, 8'h84, 16'd1025);
    // mtu over range is clamped down
    plan_cfg(REG_MTU, 32'd2047);
    plan_seg(32'hfffe_0001, 8'h11, 16'd1481);
    plan_cfg(REG_MTU, 32'd1501);
    plan_seg(32'h0001_fffe, 8'h06, 16'd1480);
    // unaligned room: last fragment may be longer than the others
    plan_cfg(REG_MTU, 32'd1103);
    plan_cfg(REG_MIN_FRAME, 32'd127);
    plan_cfg(REG_SRC_ADDR, 32'hc0a8_0102);
    plan_cfg(REG_UNUSED, 32'hffff_ffff);
    plan_seg(32'hc0a8_01fe, 8'h06, 16'd1083);
    plan_seg(32'hc0a8_01fe, 8'h06, 16'd1084);
    plan_seg(32'hc0a8_01fe, 8'h11, 16'd2163);
    plan_seg(32'h0a0a_0a0a, 8'h01, 16'd50);
    plan_cfg(REG_MIN_FRAME, 32'd64);
    plan_seg(32'h0a0a_0a0b, 8'h01, 16'd29);
    plan_seg(32'h0a0a_0a0c, 8'h01, 16'd31);

    // reset, synchronous, held low and then released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table, registers only touched once the block is idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_segment(dir_rows[i].dest, dir_rows[i].proto, dir_rows[i].seg_len,
                     dir_rows[i].typed, dir_rows[i].beat);
      end
    end

    // long run with no idling on either side
    drain();
    write_reg(REG_MTU, 32'd1500);
    write_reg(REG_MIN_FRAME, 32'd60);
    write_reg(REG_SRC_ADDR, $urandom);
    idling = 1'b0;
    repeat (60) begin
      send_segment($urandom, 8'($urandom), 16'($urandom_range(1480)), 1'b0, '0);
    end
    idling = 1'b1;

    // random phases, fresh register settings in each
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_reg(REG_SRC_ADDR, $urandom);
      pick = $urandom_range(99);
      if (pick < 70) mtu_val = 11'($urandom_range(MTU_HIGH, MTU_LOW));
      else if (pick < 85) mtu_val = 11'($urandom_range(MTU_LOW - 1, 0));
      else mtu_val = 11'($urandom_range(2047, MTU_HIGH + 1));
      // bits above the register width are junk the block must drop
      cfg_word = $urandom;
      cfg_word[10:0] = mtu_val;
      write_reg(REG_MTU, cfg_word);
      cfg_word = $urandom;
      cfg_word[6:0] = 7'($urandom_range(127));
      write_reg(REG_MIN_FRAME, cfg_word);
      repeat (64) begin
        room = payload_room();
        pick = $urandom_range(99);
        // mostly single packets, then around the edge, some fragmented, a few huge
        if (pick < 55) len = 16'($urandom_range(room));
        else if (pick < 65) len = 16'(room - 1 + $urandom_range(2));
        else if (pick < 96) len = 16'($urandom_range(4 * room, room + 1));
        else len = 16'($urandom_range(65535, 40 * room));
        send_segment($urandom, 8'($urandom), len, 1'b0, '0);
      end
    end

    // let the last beats out, then watch a while for strays
    drain();
    repeat (16) @(posedge clk);

    $display("ran %0d segments, %0d of them split, %0d header beats, %0d reg writes",
             segments_sent, fragmented_count, beats_checked, reg_writes);
    $display("mtu clamping, frame padding and back-pressure exercised over %0d cycles",
             cycle_count);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
